// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the quad projective q block.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks the consequent in the same cycle, ignored while reset is high.
`define QPQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks the consequent in the same cycle, also during reset.
`define QPQ_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/qpq_pkg.sv
// Package for the quad projective q block: output format and default sizes.
// Depends on nothing; used by every module of the block.
package qpq_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int Q_FRAC_BITS_DEFAULT = 16;
   localparam int OUT_BITS = 24;
   localparam int CORNERS = 4;

endpackage

// File: hdl/qpq_cross.sv
// Front end of the quad projective q block: diagonal differences, cross products,
// sign normalization, inside test and divisor selection in five register stages.
// Depends on qpq_pkg.
module qpq_cross #(
   parameter int COORD_BITS = qpq_pkg::COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  logic signed [COORD_BITS-1:0] llx,
   input  logic signed [COORD_BITS-1:0] lly,
   input  logic signed [COORD_BITS-1:0] lrx,
   input  logic signed [COORD_BITS-1:0] lry,
   input  logic signed [COORD_BITS-1:0] ulx,
   input  logic signed [COORD_BITS-1:0] uly,
   input  logic signed [COORD_BITS-1:0] urx,
   input  logic signed [COORD_BITS-1:0] ury,
   output logic                         out_valid,
   output logic                         out_ok,
   output logic [2*COORD_BITS+1:0]      out_den,
   output logic [2*COORD_BITS+1:0]      out_dvs_ll,
   output logic [2*COORD_BITS+1:0]      out_dvs_lr,
   output logic [2*COORD_BITS+1:0]      out_dvs_ul,
   output logic [2*COORD_BITS+1:0]      out_dvs_ur
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * COORD_BITS + 2;
   localparam int CW = 2 * COORD_BITS + 3;
   localparam int NW = 2 * COORD_BITS + 2;

   logic [4:0] valid_ff;

   logic signed [DW-1:0] d1x_ff, d1y_ff, d2x_ff, d2y_ff, ex_ff, ey_ff;
   logic signed [PW-1:0] p_d1x_d2y_ff, p_d1y_d2x_ff, p_ex_d2y_ff;
   logic signed [PW-1:0] p_ey_d2x_ff, p_ex_d1y_ff, p_ey_d1x_ff;
   logic signed [CW-1:0] den_ff, tn_ff, sn_ff;
   logic signed [CW-1:0] den_n_ff, tn_n_ff, sn_n_ff;
   logic                 ok_ff;
   logic [NW-1:0]        den_ff2, dvs_ll_ff, dvs_lr_ff, dvs_ul_ff, dvs_ur_ff;

   logic signed [CW-1:0] den_n_in, tn_n_in, sn_n_in;
   logic                 ok_in;

   always_comb begin
      if (den_ff < 0) begin
         den_n_in = -den_ff;
         tn_n_in  = -tn_ff;
         sn_n_in  = -sn_ff;
      end else begin
         den_n_in = den_ff;
         tn_n_in  = tn_ff;
         sn_n_in  = sn_ff;
      end
   end

   assign ok_in = (den_n_ff != 0) && (tn_n_ff > 0) && (tn_n_ff < den_n_ff)
                  && (sn_n_ff > 0) && (sn_n_ff < den_n_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d1x_ff <= DW'(urx) - DW'(llx);
         d1y_ff <= DW'(ury) - DW'(lly);
         d2x_ff <= DW'(lrx) - DW'(ulx);
         d2y_ff <= DW'(lry) - DW'(uly);
         ex_ff  <= DW'(ulx) - DW'(llx);
         ey_ff  <= DW'(uly) - DW'(lly);

         p_d1x_d2y_ff <= PW'(d1x_ff) * PW'(d2y_ff);
         p_d1y_d2x_ff <= PW'(d1y_ff) * PW'(d2x_ff);
         p_ex_d2y_ff  <= PW'(ex_ff) * PW'(d2y_ff);
         p_ey_d2x_ff  <= PW'(ey_ff) * PW'(d2x_ff);
         p_ex_d1y_ff  <= PW'(ex_ff) * PW'(d1y_ff);
         p_ey_d1x_ff  <= PW'(ey_ff) * PW'(d1x_ff);

         den_ff <= CW'(p_d1x_d2y_ff) - CW'(p_d1y_d2x_ff);
         tn_ff  <= CW'(p_ex_d2y_ff) - CW'(p_ey_d2x_ff);
         sn_ff  <= CW'(p_ex_d1y_ff) - CW'(p_ey_d1x_ff);

         den_n_ff <= den_n_in;
         tn_n_ff  <= tn_n_in;
         sn_n_ff  <= sn_n_in;

         ok_ff     <= ok_in;
         den_ff2   <= den_n_ff[NW-1:0];
         dvs_ll_ff <= den_n_ff[NW-1:0] - tn_n_ff[NW-1:0];
         dvs_lr_ff <= sn_n_ff[NW-1:0];
         dvs_ul_ff <= den_n_ff[NW-1:0] - sn_n_ff[NW-1:0];
         dvs_ur_ff <= tn_n_ff[NW-1:0];
      end
   end

   assign out_valid  = valid_ff[4];
   assign out_ok     = ok_ff;
   assign out_den    = den_ff2;
   assign out_dvs_ll = dvs_ll_ff;
   assign out_dvs_lr = dvs_lr_ff;
   assign out_dvs_ul = dvs_ul_ff;
   assign out_dvs_ur = dvs_ur_ff;

endmodule

// File: hdl/qpq_div.sv
// Pipelined restoring divider of the quad projective q block: one quotient bit
// per stage, fixed-point result with saturation. Depends on qpq_pkg.
module qpq_div #(
   parameter int NUM_BITS  = 2 * qpq_pkg::COORD_BITS_DEFAULT + 2,
   parameter int FRAC_BITS = qpq_pkg::Q_FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [NUM_BITS-1:0]           num,
   input  logic [NUM_BITS-1:0]           dvs,
   output logic [qpq_pkg::OUT_BITS-1:0]  quo
);

   localparam int OB = qpq_pkg::OUT_BITS;
   localparam int WW = NUM_BITS + OB;

   logic [WW-1:0]       rem_ff [0:OB];
   logic [NUM_BITS-1:0] dvs_ff [0:OB];
   logic [OB-1:0]       quo_ff [0:OB];
   logic                sat_ff [0:OB];

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= WW'(num) << FRAC_BITS;
         dvs_ff[0] <= dvs;
         quo_ff[0] <= '0;
         sat_ff[0] <= WW'(num) >= (WW'(dvs) << (OB - FRAC_BITS));
      end
   end

   for (genvar k = 0; k < OB; k++) begin : g_step
      localparam int BIT = OB - 1 - k;
      logic [WW-1:0] shifted;
      logic          ge;
      assign shifted = WW'(dvs_ff[k]) << BIT;
      assign ge      = rem_ff[k] >= shifted;
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k+1] <= ge ? rem_ff[k] - shifted : rem_ff[k];
            dvs_ff[k+1] <= dvs_ff[k];
            quo_ff[k+1] <= quo_ff[k] | (ge ? (OB'(1) << BIT) : OB'(0));
            sat_ff[k+1] <= sat_ff[k];
         end
      end
   end

   assign quo = sat_ff[OB] ? '1 : quo_ff[OB];

endmodule

// File: hdl/quad_projective_q_factors_core.sv
// Quad projective q factors: perspective weights for the four corners of a quad.
// Depends on qpq_pkg, qpq_cross, qpq_div and assert_macros.svh.
//
// Usage: one transaction on the req_ channel carries the eight corner
// coordinates; one transaction on the rsp_ channel returns the four q weights in
// tdata and the perspective flag in tuser. Quads are independent.
// From an accepted request to the valid response, a quad passes through
// five front-end stages (differences, products, cross sums, sign normalization,
// inside test), 25 divider stages (an input stage that flags quotients too large
// for the output, then 24 stages that resolve one quotient bit each, so the
// quotient width sets their number), and the output register.
// One quad per cycle unless the response stalls; four divider lanes run side by side.
// The whole pipeline moves as one: when the response is held by a low
// rsp_tready every stage holds, and req_tready drops until the response is
// taken, so nothing is lost or repeated.
// Reset clears all valid bits; the response channel is idle after reset.
// When the diagonals do not cross strictly inside the quad, every q is 1.0
// and the flag is 0. Quotients that overflow saturate at all ones.
module quad_projective_q_factors_core #(
   parameter int COORD_BITS  = qpq_pkg::COORD_BITS_DEFAULT,
   parameter int Q_FRAC_BITS = qpq_pkg::Q_FRAC_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // lower_left_x, lower_left_y, lower_right_x, lower_right_y,
   // upper_left_x, upper_left_y, upper_right_x, upper_right_y
   input  logic [8*COORD_BITS-1:0]   req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // q_lower_left, q_lower_right, q_upper_left, q_upper_right
   output logic [qpq_pkg::CORNERS*qpq_pkg::OUT_BITS-1:0] rsp_tdata,
   // perspective_valid
   output logic [0:0]                rsp_tuser
);

`include "assert_macros.svh"

   localparam int OB = qpq_pkg::OUT_BITS;
   localparam int NW = 2 * COORD_BITS + 2;
   localparam logic [OB-1:0] ONE_Q =
      (Q_FRAC_BITS >= OB) ? {OB{1'b1}} : (OB'(1) << Q_FRAC_BITS);

   logic          advance;
   logic          front_valid, front_ok;
   logic [NW-1:0] den, dvs_ll, dvs_lr, dvs_ul, dvs_ur;
   logic [OB-1:0] q_ll, q_lr, q_ul, q_ur;
   logic [OB:0]   valid_ff, ok_ff;

   logic                   rsp_valid_ff;
   logic [4*OB-1:0]        rsp_data_ff;
   logic                   rsp_flag_ff;

   logic                   all_one;
   logic                   all_at_least_one;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   qpq_cross #(.COORD_BITS(COORD_BITS)) u_cross (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_tvalid),
      .llx        (req_tdata[0*COORD_BITS +: COORD_BITS]),
      .lly        (req_tdata[1*COORD_BITS +: COORD_BITS]),
      .lrx        (req_tdata[2*COORD_BITS +: COORD_BITS]),
      .lry        (req_tdata[3*COORD_BITS +: COORD_BITS]),
      .ulx        (req_tdata[4*COORD_BITS +: COORD_BITS]),
      .uly        (req_tdata[5*COORD_BITS +: COORD_BITS]),
      .urx        (req_tdata[6*COORD_BITS +: COORD_BITS]),
      .ury        (req_tdata[7*COORD_BITS +: COORD_BITS]),
      .out_valid  (front_valid),
      .out_ok     (front_ok),
      .out_den    (den),
      .out_dvs_ll (dvs_ll),
      .out_dvs_lr (dvs_lr),
      .out_dvs_ul (dvs_ul),
      .out_dvs_ur (dvs_ur)
   );

   qpq_div #(.NUM_BITS(NW), .FRAC_BITS(Q_FRAC_BITS)) u_div_ll (
      .clock (clock), .advance (advance), .num (den), .dvs (dvs_ll), .quo (q_ll)
   );
   qpq_div #(.NUM_BITS(NW), .FRAC_BITS(Q_FRAC_BITS)) u_div_lr (
      .clock (clock), .advance (advance), .num (den), .dvs (dvs_lr), .quo (q_lr)
   );
   qpq_div #(.NUM_BITS(NW), .FRAC_BITS(Q_FRAC_BITS)) u_div_ul (
      .clock (clock), .advance (advance), .num (den), .dvs (dvs_ul), .quo (q_ul)
   );
   qpq_div #(.NUM_BITS(NW), .FRAC_BITS(Q_FRAC_BITS)) u_div_ur (
      .clock (clock), .advance (advance), .num (den), .dvs (dvs_ur), .quo (q_ur)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= {valid_ff[OB-1:0], front_valid};
         rsp_valid_ff <= valid_ff[OB];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ok_ff       <= {ok_ff[OB-1:0], front_ok};
         rsp_flag_ff <= ok_ff[OB];
         if (ok_ff[OB]) begin
            rsp_data_ff <= {q_ur, q_ul, q_lr, q_ll};
         end else begin
            rsp_data_ff <= {ONE_Q, ONE_Q, ONE_Q, ONE_Q};
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_flag_ff;

   assign all_one          = rsp_tdata == {ONE_Q, ONE_Q, ONE_Q, ONE_Q};
   assign all_at_least_one = (rsp_tdata[OB-1:0] >= ONE_Q)
                             && (rsp_tdata[2*OB-1:OB] >= ONE_Q)
                             && (rsp_tdata[3*OB-1:2*OB] >= ONE_Q)
                             && (rsp_tdata[4*OB-1:3*OB] >= ONE_Q);

   `QPQ_ASSERT_ALWAYS(a_idle_after_reset, clock, $past(reset), !rsp_tvalid, "response after reset")
   `QPQ_ASSERT_SAME(a_fallback_ones, clock, reset, rsp_tvalid && !rsp_tuser[0], all_one, "bad fallback")
   `QPQ_ASSERT_SAME(a_weights_min, clock, reset, rsp_tvalid && rsp_tuser[0], all_at_least_one, "q < 1")

endmodule
